// ----- hw/rtl/sipw_pkg.sv -----
// Package for the serial I/O pulse watchdog controller.
// Holds item kinds, reply bytes, the unlock table and shared types. No dependencies.
package sipw_pkg;

    localparam int MAX_OUTPUTS = 16;
    localparam int MAX_INPUTS  = 8;
    localparam int DEF_OUTPUT_COUNT  = 16;
    localparam int DEF_INPUT_COUNT   = 8;
    localparam int DEF_UNLOCK_LENGTH = 14;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_READY = 2'd2;

    localparam logic [2:0] REG_SHORT   = 3'd0;
    localparam logic [2:0] REG_LONG    = 3'd1;
    localparam logic [2:0] REG_RESEND  = 3'd2;
    localparam logic [2:0] REG_TPS     = 3'd3;
    localparam logic [2:0] REG_WDSEC   = 3'd4;
    localparam logic [2:0] REG_WARN    = 3'd5;
    localparam logic [2:0] REG_WDOUT   = 3'd6;
    localparam logic [2:0] REG_WDPULSE = 3'd7;

    localparam logic [7:0] BYTE_FAIL    = 8'h50;
    localparam logic [7:0] BYTE_UNLOCK  = 8'h51;
    localparam logic [7:0] BYTE_EXPIRE  = 8'h43;
    localparam logic [7:0] BYTE_WARN    = 8'h41;
    localparam logic [7:0] BYTE_OFF     = 8'h42;
    localparam logic [7:0] BYTE_PING    = 8'h40;
    localparam logic [7:0] BYTE_INPUT   = 8'h60;
    localparam logic [7:0] BYTE_STATUS  = 8'h20;
    localparam logic [7:0] BYTE_DONE    = 8'h10;

    localparam logic [3:0] CMD_SHORT  = 4'd0;
    localparam logic [3:0] CMD_LONG   = 4'd1;
    localparam logic [3:0] CMD_CLR    = 4'd2;
    localparam logic [3:0] CMD_SET    = 4'd3;
    localparam logic [3:0] CMD_WD     = 4'd4;
    localparam logic [3:0] CMD_UNLOCK = 4'd5;
    localparam logic [3:0] CMD_ACK    = 4'd6;
    localparam logic [3:0] CMD_READ   = 4'd7;

    typedef struct packed {
        logic [7:0] short_ticks;
        logic [7:0] long_ticks;
        logic [7:0] resend_ticks;
        logic [7:0] tps;
        logic [7:0] wd_seconds;
        logic [7:0] warn_seconds;
        logic [3:0] wd_output;
        logic [7:0] wd_pulse;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       rx_error;
        logic [7:0] input_pins;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [15:0] output_pins;
        logic [2:0]  monitor_leds;
        logic        send_request;
    } result_t;

    function automatic logic [3:0] unlock_nibble(input logic [3:0] idx);
        case (idx)
            4'd0:  unlock_nibble = 4'h4;
            4'd1:  unlock_nibble = 4'ha;
            4'd2:  unlock_nibble = 4'h7;
            4'd3:  unlock_nibble = 4'h5;
            4'd4:  unlock_nibble = 4'h6;
            4'd5:  unlock_nibble = 4'h2;
            4'd6:  unlock_nibble = 4'h6;
            4'd7:  unlock_nibble = 4'ha;
            4'd8:  unlock_nibble = 4'h7;
            4'd9:  unlock_nibble = 4'h5;
            4'd10: unlock_nibble = 4'h6;
            4'd11: unlock_nibble = 4'h2;
            4'd12: unlock_nibble = 4'h2;
            4'd13: unlock_nibble = 4'h1;
            default: unlock_nibble = 4'h0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/sipw_cfg.sv -----
// Configuration register file of the serial I/O pulse watchdog controller.
// Depends on sipw_pkg.
module sipw_cfg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    output sipw_pkg::cfg_t  cfg
);
    import sipw_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{8'd10, 8'd250, 8'd50, 8'd50, 8'd60, 8'd15, 4'd0, 8'd10};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SHORT:   cfg_reg.short_ticks  <= cfg_data;
                REG_LONG:    cfg_reg.long_ticks   <= cfg_data;
                REG_RESEND:  cfg_reg.resend_ticks <= cfg_data;
                REG_TPS:     cfg_reg.tps          <= cfg_data;
                REG_WDSEC:   cfg_reg.wd_seconds   <= cfg_data;
                REG_WARN:    cfg_reg.warn_seconds <= cfg_data;
                REG_WDOUT:   cfg_reg.wd_output    <= cfg_data[3:0];
                REG_WDPULSE: cfg_reg.wd_pulse     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ----- hw/rtl/sipw_core.sv -----
// State and next-state logic of the serial I/O pulse watchdog controller.
// Takes one registered word per cycle while item_valid is high and produces its result. Depends on sipw_pkg.
module sipw_core #(
    parameter int OUTPUT_COUNT  = sipw_pkg::DEF_OUTPUT_COUNT,
    parameter int INPUT_COUNT   = sipw_pkg::DEF_INPUT_COUNT,
    parameter int UNLOCK_LENGTH = sipw_pkg::DEF_UNLOCK_LENGTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  sipw_pkg::item_t     item,
    input  sipw_pkg::cfg_t      cfg,
    output sipw_pkg::result_t   result
);
    import sipw_pkg::*;

    logic [7:0]  pulse_left_reg [MAX_OUTPUTS];
    logic [7:0]  pulse_left_next [MAX_OUTPUTS];
    logic [7:0]  resend_left_reg [MAX_INPUTS];
    logic [7:0]  resend_left_next [MAX_INPUTS];
    logic [15:0] ack_reg, ack_next, done_reg, done_next, stat_reg, stat_next;
    logic [15:0] lvl_reg, lvl_next, pin_reg, pin_next;
    logic [7:0]  inl_reg, inl_next, inp_reg, inp_next;
    logic [7:0]  wdt_reg, wdt_next, wds_reg, wds_next;
    logic [3:0]  wdf_reg, wdf_next;
    logic        link_reg, link_next, sen_reg, sen_next;
    logic [3:0]  uidx_reg, uidx_next;
    logic [1:0]  rxl_reg, rxl_next, txl_reg, txl_next;
    logic [2:0]  led_reg, led_next;
    logic        txv;
    logic [7:0]  txb;
    logic        picked;
    logic [15:0] lv;
    logic [3:0]  n, k, uinc;
    logic [2:0]  ii;

    always_comb begin
        for (int i = 0; i < MAX_OUTPUTS; i++) pulse_left_next[i] = pulse_left_reg[i];
        for (int i = 0; i < MAX_INPUTS; i++) resend_left_next[i] = resend_left_reg[i];
        ack_next = ack_reg; done_next = done_reg; stat_next = stat_reg;
        lvl_next = lvl_reg; pin_next = pin_reg; inl_next = inl_reg; inp_next = inp_reg;
        wdt_next = wdt_reg; wds_next = wds_reg; wdf_next = wdf_reg;
        link_next = link_reg; sen_next = sen_reg; uidx_next = uidx_reg;
        rxl_next = rxl_reg; txl_next = txl_reg; led_next = led_reg;
        txv = 1'b0; txb = 8'h00; picked = 1'b0; lv = '0;
        n = item.rx_byte[3:0]; k = item.rx_byte[7:4]; ii = item.rx_byte[2:0];
        uinc = uidx_reg + 4'd1;
        if (item_valid) begin
            case (item.func)
                FUNC_TICK: begin
                    for (int i = 0; i < OUTPUT_COUNT; i++) begin
                        lv[i] = lvl_reg[i];
                        if (pulse_left_reg[i] != 8'd0) begin
                            lv[i] = ~lvl_reg[i];
                            pulse_left_next[i] = pulse_left_reg[i] - 8'd1;
                            if (pulse_left_reg[i] == 8'd1) begin
                                done_next[i] = 1'b1;
                                sen_next = 1'b1;
                            end
                        end
                    end
                    pin_next = lv;
                    for (int i = 0; i < INPUT_COUNT; i++) begin
                        if (resend_left_reg[i] != 8'd0) begin
                            resend_left_next[i] = resend_left_reg[i] - 8'd1;
                            if (resend_left_reg[i] == 8'd1) begin
                                inp_next[i] = 1'b1;
                                resend_left_next[i] = cfg.resend_ticks;
                                sen_next = 1'b1;
                            end
                        end
                        if (item.input_pins[i] != inl_reg[i]) begin
                            inl_next[i] = item.input_pins[i];
                            inp_next[i] = 1'b1;
                            resend_left_next[i] = cfg.resend_ticks;
                            sen_next = 1'b1;
                        end
                    end
                    if (wdf_reg[0]) begin
                        wdt_next = wdt_reg - 8'd1;
                        if (wdt_reg == 8'd1) begin
                            wdt_next = cfg.tps;
                            wds_next = wds_reg - 8'd1;
                            if (wds_next == cfg.warn_seconds) begin
                                wdf_next[1] = 1'b1;
                                sen_next = 1'b1;
                            end
                            if (wds_reg == 8'd1) begin
                                if (32'(cfg.wd_output) < OUTPUT_COUNT)
                                    pulse_left_next[cfg.wd_output] = cfg.wd_pulse;
                                txv = 1'b1; txb = BYTE_EXPIRE;
                                wdf_next[0] = 1'b0;
                                link_next = 1'b0;
                                sen_next = 1'b0;
                            end
                        end
                    end
                    led_next = {txl_reg != 2'd0, rxl_reg != 2'd0, link_next};
                    if (rxl_reg != 2'd0) rxl_next = rxl_reg - 2'd1;
                    if (txl_reg != 2'd0) txl_next = txl_reg - 2'd1;
                end
                FUNC_RX: begin
                    rxl_next = 2'd3;
                    if (item.rx_error) begin
                        txv = 1'b1; txb = BYTE_FAIL; link_next = 1'b0; sen_next = 1'b0;
                    end else if (k == CMD_UNLOCK) begin
                        link_next = 1'b0;
                        if (unlock_nibble(uidx_reg) == n) begin
                            uidx_next = uinc;
                            if (32'(uinc) >= UNLOCK_LENGTH || uinc == 4'd0) begin
                                link_next = 1'b1;
                                txv = 1'b1; txb = BYTE_UNLOCK;
                                for (int i = 0; i < OUTPUT_COUNT; i++) begin
                                    pulse_left_next[i] = 8'd0;
                                    stat_next[i] = 1'b1;
                                end
                                for (int i = 0; i < INPUT_COUNT; i++) begin
                                    resend_left_next[i] = cfg.resend_ticks;
                                    inp_next[i] = 1'b1;
                                end
                                if (wdf_reg[0]) wdf_next[1] = 1'b1;
                                else wdf_next[3] = 1'b1;
                                sen_next = 1'b1;
                                uidx_next = 4'd0;
                            end
                        end else begin
                            uidx_next = (unlock_nibble(4'd0) == n) ? 4'd1 : 4'd0;
                            sen_next = 1'b0;
                        end
                    end else if (!link_reg) begin
                        txv = 1'b1; txb = BYTE_FAIL; link_next = 1'b0; sen_next = 1'b0;
                    end else begin
                        case (k)
                            CMD_SHORT, CMD_LONG: begin
                                if (32'(n) < OUTPUT_COUNT) begin
                                    pulse_left_next[n] = k[0] ? cfg.long_ticks
                                                              : cfg.short_ticks;
                                    ack_next[n] = 1'b1;
                                    sen_next = 1'b1;
                                end
                            end
                            CMD_CLR, CMD_SET: begin
                                if (32'(n) < OUTPUT_COUNT) begin
                                    lvl_next[n] = k[0];
                                    stat_next[n] = 1'b1;
                                    sen_next = 1'b1;
                                end
                            end
                            CMD_WD: begin
                                if (n == 4'd0 || n == 4'd1) begin
                                    if (n == 4'd0) wdf_next[0] = 1'b1;
                                    wdt_next = cfg.tps;
                                    wds_next = cfg.wd_seconds;
                                    wdf_next[2] = 1'b1;
                                    sen_next = 1'b1;
                                end else if (n == 4'd2) begin
                                    wdf_next[0] = 1'b0;
                                    wdf_next[3] = 1'b1;
                                    sen_next = 1'b1;
                                end else begin
                                    txv = 1'b1; txb = BYTE_FAIL;
                                    link_next = 1'b0; sen_next = 1'b0;
                                end
                            end
                            CMD_ACK: begin
                                if (32'(ii) < INPUT_COUNT) begin
                                    if (inl_reg[ii] == item.rx_byte[3]) begin
                                        resend_left_next[ii] = 8'd0;
                                    end else begin
                                        inp_next[ii] = 1'b1;
                                        resend_left_next[ii] = cfg.resend_ticks;
                                        sen_next = 1'b1;
                                    end
                                end
                            end
                            CMD_READ: begin
                                if (32'(n) < OUTPUT_COUNT) begin
                                    stat_next[n] = 1'b1;
                                    sen_next = 1'b1;
                                end
                            end
                            default: begin
                                txv = 1'b1; txb = BYTE_FAIL;
                                link_next = 1'b0; sen_next = 1'b0;
                            end
                        endcase
                    end
                end
                FUNC_READY: begin
                    if (sen_reg) begin
                        if (link_reg) begin
                            if (wdf_reg[1]) begin
                                wdf_next[1] = 1'b0; txb = BYTE_WARN; picked = 1'b1;
                            end else if (wdf_reg[3]) begin
                                wdf_next[3] = 1'b0; txb = BYTE_OFF; picked = 1'b1;
                            end else if (wdf_reg[2]) begin
                                wdf_next[2] = 1'b0; txb = BYTE_PING; picked = 1'b1;
                            end else begin
                                // Lowest output first; within one output ack, done, status.
                                for (int i = OUTPUT_COUNT - 1; i >= 0; i--) begin
                                    if (ack_reg[i] || done_reg[i] || stat_reg[i]) begin
                                        picked = 1'b1;
                                        ack_next = ack_reg; done_next = done_reg;
                                        stat_next = stat_reg;
                                        if (ack_reg[i]) begin
                                            ack_next[i] = 1'b0; txb = 8'(i);
                                        end else if (done_reg[i]) begin
                                            done_next[i] = 1'b0;
                                            txb = BYTE_DONE | 8'(i);
                                        end else begin
                                            stat_next[i] = 1'b0;
                                            txb = BYTE_STATUS | 8'(i) | {3'b0, lvl_reg[i], 4'b0};
                                        end
                                    end
                                end
                                if (!picked) begin
                                    for (int i = INPUT_COUNT - 1; i >= 0; i--) begin
                                        if (inp_reg[i]) begin
                                            picked = 1'b1;
                                            inp_next = inp_reg;
                                            inp_next[i] = 1'b0;
                                            txb = BYTE_INPUT | 8'(i) | {4'b0, inl_reg[i], 3'b0};
                                        end
                                    end
                                end
                            end
                        end
                        if (picked) begin
                            txv = 1'b1; txl_next = 2'd3;
                        end else begin
                            sen_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!txv) txb = 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_OUTPUTS; i++) pulse_left_reg[i] <= 8'd0;
            for (int i = 0; i < MAX_INPUTS; i++) resend_left_reg[i] <= 8'd0;
            ack_reg <= '0; done_reg <= '0; stat_reg <= '0; lvl_reg <= '0; pin_reg <= '0;
            inl_reg <= '0; inp_reg <= '0; wdt_reg <= '0; wds_reg <= '0; wdf_reg <= '0;
            link_reg <= 1'b0; sen_reg <= 1'b0; uidx_reg <= '0;
            rxl_reg <= '0; txl_reg <= '0; led_reg <= '0;
        end else begin
            for (int i = 0; i < MAX_OUTPUTS; i++) pulse_left_reg[i] <= pulse_left_next[i];
            for (int i = 0; i < MAX_INPUTS; i++) resend_left_reg[i] <= resend_left_next[i];
            ack_reg <= ack_next; done_reg <= done_next; stat_reg <= stat_next;
            lvl_reg <= lvl_next; pin_reg <= pin_next; inl_reg <= inl_next;
            inp_reg <= inp_next; wdt_reg <= wdt_next; wds_reg <= wds_next;
            wdf_reg <= wdf_next; link_reg <= link_next; sen_reg <= sen_next;
            uidx_reg <= uidx_next; rxl_reg <= rxl_next; txl_reg <= txl_next;
            led_reg <= led_next;
        end
    end

    assign result = '{txv, txb, pin_next, led_next, sen_next};

`ifndef SYNTHESIS
    a_link_drops_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && result.tx_valid && result.tx_byte == BYTE_FAIL) |=> !link_reg)
        else $error("link still up after fail byte");
    a_txbyte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !result.tx_valid |-> result.tx_byte == 8'h00)
        else $error("tx byte set without tx valid");
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid |=> $stable(link_reg) && $stable(sen_reg) && $stable(pin_reg))
        else $error("state changed without a word");
`endif
endmodule

// ----- hw/rtl/serial_io_pulse_watchdog_ctrl.sv -----
// Top level of the serial I/O pulse watchdog controller.
// Input register, core and result register with skid. Depends on sipw_pkg, sipw_cfg, sipw_core.
//
//  channel   | direction | tdata fields (low bit up)                | tuser
//  s_axis    | in        | rx_byte[7:0], rx_error[8], input_pins    | func[1:0]
//  m_axis    | out       | tx_byte, output_pins, monitor_leds, send | tx_valid
//  cfg       | in        | cfg_wdata[7:0] at cfg_index              | -
//
// One word per cycle while the output is not stalled; the core evaluates a word combinationally
// between the input register and the result register.
// Reset is synchronous on aresetn low; it clears the valid flags and core state and loads the default configuration.
// A stalled result is held in the output register while one more word can wait
// in the input register; s_tready drops only when both are full.
module serial_io_pulse_watchdog_ctrl #(
    parameter int OUTPUT_COUNT  = sipw_pkg::DEF_OUTPUT_COUNT,
    parameter int INPUT_COUNT   = sipw_pkg::DEF_INPUT_COUNT,
    parameter int UNLOCK_LENGTH = sipw_pkg::DEF_UNLOCK_LENGTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte, rx_error, input_pins, zero fill
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte, output_pins, monitor_leds, send_request, fill
    output logic        m_tuser,   // tx_valid
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import sipw_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res, out_reg;
    logic    out_valid_reg;
    logic    advance;

    sipw_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_wdata), .cfg(cfg)
    );

    // The core consumes the input word only when the result register can take it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sipw_core #(
        .OUTPUT_COUNT(OUTPUT_COUNT), .INPUT_COUNT(INPUT_COUNT),
        .UNLOCK_LENGTH(UNLOCK_LENGTH)
    ) u_core (
        .aclk(aclk), .aresetn(aresetn), .item_valid(advance),
        .item(in_reg), .cfg(cfg), .result(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid)
            in_reg <= '{s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[16:9]};
        if (advance) out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.tx_valid;
    assign m_tdata  = {4'b0, out_reg.send_request, out_reg.monitor_leds,
                       out_reg.output_pins, out_reg.tx_byte};

`ifndef SYNTHESIS
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("not ready with empty input register");
    a_adv_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result lost");
`endif
endmodule
